@@ hw/rtl/blpwb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwb_pkg: shared constants and helpers for the pixel write/blend block
// Register indexes, field widths, reset values and the channel mix function.
// ----------------------------------------------------------------------------
package blpwb_pkg;

    localparam int COORD_W   = 13;
    localparam int DIM_W     = 12;
    localparam int PIXEL_W   = 16;
    localparam int OFFSET_W  = 22;
    localparam int CH_W      = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 12'd448;
    localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 12'd720;

    localparam logic [CH_W-1:0] CH_MAX = 4'hF;

    // Reciprocal of 15 scaled by 2^11; exact floor for sums up to 225
    localparam logic [7:0] RECIP15 = 8'd137;
    localparam int         RECIP_SH = 11;

    typedef logic [CH_W-1:0] chan_t;

    // floor((n*a + o*(15-a)) / 15)
    function automatic chan_t mix_channel(input chan_t n, input chan_t o, input chan_t a);
        logic [7:0]  sum;
        logic [15:0] scaled;
        sum    = 8'(n * a) + 8'(o * (CH_MAX - a));
        scaled = 16'(sum) * 16'(RECIP15);
        return chan_t'(scaled >> RECIP_SH);
    endfunction

endpackage

@@ hw/rtl/block_linear_pixel_write_blend_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_linear_pixel_write_blend_top: per-pixel write unit
// Bounds check, block-linear swizzle and RGBA4444 set or blend of one pixel.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle (busy stays low); its result appears
// with done high for exactly one cycle, after passing through the input
// register and then through the swizzle and blend logic into the result
// register. The receiver cannot stall, so results must be taken as they come.
// Write fb_width and fb_height only while no request is in flight.
module block_linear_pixel_write_blend_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic signed [blpwb_pkg::COORD_W-1:0] pos_x,
    input  logic signed [blpwb_pkg::COORD_W-1:0] pos_y,
    input  logic [blpwb_pkg::PIXEL_W-1:0]       new_color,
    input  logic [blpwb_pkg::PIXEL_W-1:0]       old_pixel,
    input  logic                                frame_open,
    output logic                                done,
    output logic                                write_enable,
    output logic [blpwb_pkg::OFFSET_W-1:0]      word_offset,
    output logic [blpwb_pkg::PIXEL_W-1:0]       pixel_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [blpwb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [blpwb_pkg::DIM_W-1:0]         cfg_data
);
    import blpwb_pkg::*;

    logic [DIM_W-1:0]   fb_width_reg,  fb_width_next;
    logic [DIM_W-1:0]   fb_height_reg, fb_height_next;

    logic               in_valid_reg;
    logic               action_reg;
    logic [COORD_W-1:0] pos_x_reg, pos_y_reg;
    logic [PIXEL_W-1:0] new_color_reg, old_pixel_reg;
    logic               frame_open_reg;

    logic               done_reg;
    logic               write_enable_reg;
    logic [OFFSET_W-1:0] word_offset_reg, word_offset_next;
    logic [PIXEL_W-1:0] pixel_word_reg, pixel_word_next;

    logic               ok;
    logic [DIM_W-1:0]   x, y;
    logic [DIM_W-1:0]   band_mul;
    logic [15:0]        band;
    logic [PIXEL_W-1:0] blended;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_comb
    begin
        fb_width_next  = fb_width_reg;
        fb_height_next = fb_height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FB_WIDTH:  fb_width_next  = cfg_data;
                CFG_FB_HEIGHT: fb_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= FB_WIDTH_RST;
            fb_height_reg <= FB_HEIGHT_RST;
        end
        else
        begin
            fb_width_reg  <= fb_width_next;
            fb_height_reg <= fb_height_next;
        end
    end

    // Input register: capture every beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            action_reg     <= action;
            pos_x_reg      <= pos_x;
            pos_y_reg      <= pos_y;
            new_color_reg  <= new_color;
            old_pixel_reg  <= old_pixel;
            frame_open_reg <= frame_open;
        end
    end

    // Sign bit set means negative, so the low 12 bits suffice when in bounds
    assign x  = pos_x_reg[DIM_W-1:0];
    assign y  = pos_y_reg[DIM_W-1:0];
    assign ok = frame_open_reg && !pos_x_reg[COORD_W-1] && !pos_y_reg[COORD_W-1]
                && (x < fb_width_reg) && (y < fb_height_reg);

    // Band index: 16-row strip within the 128-row band, 32-column block, band row
    assign band_mul = {7'd0, y[11:7]} * {5'd0, fb_width_reg[11:5]};
    assign band     = 16'(y[6:4]) + {6'd0, x[11:5], 3'b000} + {1'b0, band_mul, 3'b000};

    blpwb_blend u_blend (
        .new_color (new_color_reg),
        .old_pixel (old_pixel_reg),
        .blended   (blended)
    );

    always_comb
    begin
        word_offset_next = '0;
        pixel_word_next  = '0;
        if (ok)
        begin
            word_offset_next = {band[12:0], y[3], x[4], y[2:1], x[3], y[0], x[2:0]};
            pixel_word_next  = action_reg ? blended : new_color_reg;
        end
    end

    // Result register: one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            write_enable_reg <= 1'b0;
        end
        else
        begin
            done_reg         <= in_valid_reg;
            write_enable_reg <= in_valid_reg && ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            word_offset_reg <= word_offset_next;
            pixel_word_reg  <= pixel_word_next;
        end
    end

    assign done         = done_reg;
    assign write_enable = write_enable_reg;
    assign word_offset  = word_offset_reg;
    assign pixel_word   = pixel_word_reg;

endmodule

@@ hw/rtl/blpwb_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwb_blend: RGBA4444 alpha blend
// Mixes R, G and B by the new alpha and saturates the summed alpha.
// ----------------------------------------------------------------------------
module blpwb_blend (
    input  logic [blpwb_pkg::PIXEL_W-1:0] new_color,
    input  logic [blpwb_pkg::PIXEL_W-1:0] old_pixel,
    output logic [blpwb_pkg::PIXEL_W-1:0] blended
);
    import blpwb_pkg::*;

    chan_t       alpha;
    logic [4:0]  alpha_sum;
    chan_t       alpha_out;

    assign alpha     = new_color[15:12];
    assign alpha_sum = {1'b0, alpha} + {1'b0, old_pixel[15:12]};
    assign alpha_out = alpha_sum[4] ? CH_MAX : alpha_sum[3:0];

    assign blended = {alpha_out,
                      mix_channel(new_color[11:8], old_pixel[11:8], alpha),
                      mix_channel(new_color[7:4],  old_pixel[7:4],  alpha),
                      mix_channel(new_color[3:0],  old_pixel[3:0],  alpha)};

endmodule

@@ hw/rtl/blpwb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwb_checker: port-level checks for the pixel write unit
// Latency, spurious results, suppressed-write zeroing, offset low bits and write strobe, bound to the top.
// ----------------------------------------------------------------------------
module blpwb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [12:0] pos_x,
    input logic        done,
    input logic        write_enable,
    input logic [21:0] word_offset,
    input logic [15:0] pixel_word
);

    // Every accepted beat yields a result, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat produced no result");

    // No result without an accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without accepted beat");

    // Suppressed writes carry zero fields
    a_suppress_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_enable) |-> (word_offset == 22'd0 && pixel_word == 16'd0))
        else $error("suppressed write has non-zero fields");

    // Offset low bits follow the column of the beat
    a_offset_low: assert property (@(posedge clk) disable iff (!rst_n)
        (done && write_enable) |-> (word_offset[2:0] == $past(pos_x[2:0], 2)))
        else $error("offset low bits do not match column");

    // Write enable only on a result cycle
    a_we_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        write_enable |-> done)
        else $error("write enable outside result cycle");

endmodule

bind block_linear_pixel_write_blend_top blpwb_checker u_blpwb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .pos_x        (pos_x),
    .done         (done),
    .write_enable (write_enable),
    .word_offset  (word_offset),
    .pixel_word   (pixel_word)
);
